### design/ipba_pkg.sv
// Shared types, constants and arithmetic helpers for the projected bbox accumulator.
`timescale 1ns / 1ps
package ipba_pkg;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_BOX  = 2'd1;
    localparam logic [1:0] CMD_EMIT = 2'd2;

    localparam logic [2:0] REG_COS    = 3'd0;
    localparam logic [2:0] REG_SIN    = 3'd1;
    localparam logic [2:0] REG_SDX    = 3'd2;
    localparam logic [2:0] REG_SDY    = 3'd3;
    localparam logic [2:0] REG_SEN    = 3'd4;

    localparam logic signed [31:0] MAX32 = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MIN32 = 32'sh8000_0000;
    localparam longint SQRT_HALF_Q30 = 759250125;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROWS,
        ST_ROT,
        ST_PROJ,
        ST_SHAD,
        ST_GROW
    } t_bstate;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [1:0]         row;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
    } t_entry;

    function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       sat66 = MAX32;
        else if (v < -66'sd2147483648) sat66 = MIN32;
        else                           sat66 = v[31:0];
    endfunction

endpackage

### design/ipba_front.sv
// Front end: accepts commands, latches limb boxes, queues work for the back end.
`timescale 1ns / 1ps
module ipba_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  logic [1:0]           i_row,
    input  logic signed [31:0]   i_coef_a,
    input  logic signed [31:0]   i_coef_b,
    input  logic signed [31:0]   i_coef_c,
    input  logic signed [31:0]   i_coef_d,
    input  logic signed [31:0]   i_lo_x,
    input  logic signed [31:0]   i_lo_y,
    input  logic signed [31:0]   i_lo_z,
    input  logic signed [31:0]   i_hi_x,
    input  logic signed [31:0]   i_hi_y,
    input  logic signed [31:0]   i_hi_z,
    output logic                 o_q_valid,
    output ipba_pkg::t_entry     o_q_entry,
    output logic signed [31:0]   o_q_hy,
    output logic signed [31:0]   o_q_hz,
    input  logic                 i_q_pop
);
    import ipba_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    logic       r_wp, r_rp;
    t_entry     r_q [2];
    logic signed [31:0] r_hy [2];
    logic signed [31:0] r_hz [2];
    t_entry     w_in;
    logic       w_push, w_keep;

    // commands that do nothing are dropped here
    always_comb begin
        w_keep = 1'b0;
        case (i_cmd)
            CMD_LOAD: w_keep = (i_row != 2'd3);
            CMD_BOX, CMD_EMIT: w_keep = 1'b1;
            default: w_keep = 1'b0;
        endcase
        w_in.cmd = i_cmd;
        w_in.row = i_row;
        if (i_cmd == CMD_BOX) begin
            // pack box as lo x/y/z in a,b,c and hi x in d; hi y/z ride alongside
            w_in.a = i_lo_x; w_in.b = i_lo_y; w_in.c = i_lo_z; w_in.d = i_hi_x;
        end else begin
            w_in.a = i_coef_a; w_in.b = i_coef_b; w_in.c = i_coef_c; w_in.d = i_coef_d;
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall && w_keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_entry = r_q[r_rp];
    assign o_q_hy    = r_hy[r_rp];
    assign o_q_hz    = r_hz[r_rp];

    always_comb begin
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
        end
        if (w_push) begin
            r_q[r_wp]  <= w_in;
            r_hy[r_wp] <= i_hi_y;
            r_hz[r_wp] <= i_hi_z;
        end
    end
endmodule

### design/iso_projected_bbox_accumulator.sv
// Top level of the isometric projected bounding-box accumulator.
`timescale 1ns / 1ps
// Usage:
//   Input channel (i_valid/o_stall) carries one command per transfer:
//   load transform row, process limb box, or emit and clear.
//   Output channel (o_valid/i_stall) carries one result per emit.
//   Config channel (i_cfg_valid/o_cfg_ready) writes yaw and shadow registers;
//   it is always ready.
//   A two-entry queue separates command intake from the corner engine.
//   The engine handles a row load or an emit in its idle state; a limb box
//   runs its 8 corners in turn, and each corner goes through the row
//   multiply, yaw rotation, projection and shadow offset, shadow projection
//   and grow steps.
//   An accepted emit is queued, then popped into the output register, which
//   raises o_valid, once the engine is idle and no result is held stalled.
//   A stalled result holds in the output register; the engine waits only if
//   a second emit reaches it meanwhile.
//   Reset clears the queue, the accumulators to their empty values and the
//   registers to their defaults; transform rows are undefined until loaded.
module iso_projected_bbox_accumulator #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    input  logic [1:0]         i_row,
    input  logic signed [31:0] i_coef_a,
    input  logic signed [31:0] i_coef_b,
    input  logic signed [31:0] i_coef_c,
    input  logic signed [31:0] i_coef_d,
    input  logic signed [31:0] i_lo_x,
    input  logic signed [31:0] i_lo_y,
    input  logic signed [31:0] i_lo_z,
    input  logic signed [31:0] i_hi_x,
    input  logic signed [31:0] i_hi_y,
    input  logic signed [31:0] i_hi_z,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_left_edge,
    output logic signed [31:0] o_top_edge,
    output logic signed [31:0] o_right_edge,
    output logic signed [31:0] o_bottom_edge,
    output logic signed [31:0] o_near_depth,
    output logic signed [31:0] o_far_depth
);
    import ipba_pkg::*;

    localparam int S = 30 - FRAC_BITS;
    localparam longint KL = (SQRT_HALF_Q30 + (longint'(1) <<< (S - 1))) >>> S;
    localparam logic signed [31:0] K = 32'(KL);

    // ---------------- queue (front) ----------------
    logic               w_q_valid, w_pop;
    t_entry             w_q_entry;
    logic signed [31:0] w_q_hy, w_q_hz;

    ipba_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_cmd     (i_cmd),
        .i_row     (i_row),
        .i_coef_a  (i_coef_a),
        .i_coef_b  (i_coef_b),
        .i_coef_c  (i_coef_c),
        .i_coef_d  (i_coef_d),
        .i_lo_x    (i_lo_x),
        .i_lo_y    (i_lo_y),
        .i_lo_z    (i_lo_z),
        .i_hi_x    (i_hi_x),
        .i_hi_y    (i_hi_y),
        .i_hi_z    (i_hi_z),
        .o_q_valid (w_q_valid),
        .o_q_entry (w_q_entry),
        .o_q_hy    (w_q_hy),
        .o_q_hz    (w_q_hz),
        .i_q_pop   (w_pop)
    );

    // ---------------- config ----------------
    logic signed [17:0] r_cos, r_sin;
    logic signed [31:0] r_sdx, r_sdy;
    logic               r_sen;
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= 18'sd65536; r_sin <= '0;
            r_sdx <= 32'sd32768; r_sdy <= 32'sd32768; r_sen <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COS: r_cos <= i_cfg_data[17:0];
                REG_SIN: r_sin <= i_cfg_data[17:0];
                REG_SDX: r_sdx <= i_cfg_data;
                REG_SDY: r_sdy <= i_cfg_data;
                REG_SEN: r_sen <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- back end ----------------
    logic signed [31:0] r_m [12];
    t_bstate r_st, n_st;
    logic [2:0] r_corner;
    logic signed [31:0] r_px, r_py, r_pz, r_wx, r_wy, r_qx, r_qy;
    logic signed [31:0] r_sx, r_sy, r_gx, r_gy, r_dp;
    logic signed [31:0] r_al, r_at, r_ar, r_ab, r_an, r_af;
    logic               r_ov;
    logic signed [31:0] r_ol, r_ot, r_or, r_ob, r_on, r_of;

    logic [1:0] w_hcmd, w_hrow;
    logic signed [31:0] w_x, w_y, w_z;
    logic       w_emit, w_load;
    assign w_hcmd = w_q_entry.cmd;
    assign w_hrow = w_q_entry.row;
    assign w_x = r_corner[0] ? w_q_entry.d : w_q_entry.a;
    assign w_y = r_corner[1] ? w_q_hy : w_q_entry.b;
    assign w_z = r_corner[2] ? w_q_hz : w_q_entry.c;

    function automatic logic signed [63:0] fmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        fmul = p >>> FRAC_BITS;
    endfunction

    function automatic logic signed [31:0] rowf(input logic signed [31:0] a,
        input logic signed [31:0] b, input logic signed [31:0] c,
        input logic signed [31:0] d, input logic signed [31:0] x,
        input logic signed [31:0] y, input logic signed [31:0] z);
        logic signed [65:0] s;
        s = 66'(fmul(a, x)) + 66'(fmul(b, y)) + 66'(fmul(c, z)) + 66'(d);
        rowf = sat66(s);
    endfunction

    function automatic logic signed [31:0] projk(input logic signed [32:0] v,
                                                 input int sh);
        logic signed [65:0] p;
        logic signed [65:0] q;
        p = 66'(v) * 66'(K);
        q = p >>> sh;
        projk = sat66(q);
    endfunction

    logic w_idle_ok;
    assign w_idle_ok = !(r_ov && i_stall);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_q_valid && w_hcmd == CMD_BOX) n_st = ST_ROWS;
            end
            ST_ROWS: n_st = ST_ROT;
            ST_ROT:  n_st = ST_PROJ;
            ST_PROJ: n_st = ST_SHAD;
            ST_SHAD: n_st = ST_GROW;
            ST_GROW: n_st = (r_corner == 3'd7) ? ST_IDLE : ST_ROWS;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_pop = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (w_q_valid) begin
                    case (w_hcmd)
                        CMD_BOX:  w_pop = 1'b0;
                        CMD_EMIT: w_pop = w_idle_ok;
                        default:  w_pop = 1'b1;
                    endcase
                end
            end
            ST_GROW: w_pop = (r_corner == 3'd7);
            default: w_pop = 1'b0;
        endcase
    end

    assign w_emit = (r_st == ST_IDLE) && w_pop && (w_hcmd == CMD_EMIT);
    assign w_load = (r_st == ST_IDLE) && w_pop && (w_hcmd == CMD_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_corner <= '0;
            r_ov <= 1'b0;
            r_al <= MAX32; r_at <= MAX32; r_an <= MAX32;
            r_ar <= MIN32; r_ab <= MIN32; r_af <= MIN32;
        end else begin
            r_st <= n_st;
            if (w_emit) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    r_corner <= '0;
                    if (w_emit) begin
                        r_ol <= r_al; r_ot <= r_at; r_or <= r_ar;
                        r_ob <= r_ab; r_on <= r_an; r_of <= r_af;
                        r_al <= MAX32; r_at <= MAX32; r_an <= MAX32;
                        r_ar <= MIN32; r_ab <= MIN32; r_af <= MIN32;
                    end
                end
                ST_GROW: begin
                    r_corner <= r_corner + 3'd1;
                    if (r_sx < r_al) r_al <= (r_gx < r_sx) ? r_gx : r_sx;
                    else if (r_gx < r_al) r_al <= r_gx;
                    if (r_sx > r_ar) r_ar <= (r_gx > r_sx) ? r_gx : r_sx;
                    else if (r_gx > r_ar) r_ar <= r_gx;
                    if (r_sy < r_at) r_at <= (r_gy < r_sy) ? r_gy : r_sy;
                    else if (r_gy < r_at) r_at <= r_gy;
                    if (r_sy > r_ab) r_ab <= (r_gy > r_sy) ? r_gy : r_sy;
                    else if (r_gy > r_ab) r_ab <= r_gy;
                    if (r_dp < r_an) r_an <= r_dp;
                    if (r_dp > r_af) r_af <= r_dp;
                end
                default: ;
            endcase
        end
        if (w_load) begin
            r_m[{w_hrow, 2'b00}] <= w_q_entry.a;
            r_m[{w_hrow, 2'b01}] <= w_q_entry.b;
            r_m[{w_hrow, 2'b10}] <= w_q_entry.c;
            r_m[{w_hrow, 2'b11}] <= w_q_entry.d;
        end
        case (r_st)
            ST_ROWS: begin
                r_px <= rowf(r_m[0], r_m[1], r_m[2], r_m[3], w_x, w_y, w_z);
                r_py <= rowf(r_m[4], r_m[5], r_m[6], r_m[7], w_x, w_y, w_z);
                r_pz <= rowf(r_m[8], r_m[9], r_m[10], r_m[11], w_x, w_y, w_z);
            end
            ST_ROT: begin
                r_wx <= sat66(66'(fmul(32'(r_cos), r_px)) - 66'(fmul(32'(r_sin), r_py)));
                r_wy <= sat66(66'(fmul(32'(r_sin), r_px)) + 66'(fmul(32'(r_cos), r_py)));
            end
            ST_PROJ: begin
                r_sx <= projk(33'(r_wx) - 33'(r_wy), FRAC_BITS);
                r_sy <= sat66(66'(projk(33'(r_wx) + 33'(r_wy), FRAC_BITS + 1))
                              - 66'(r_pz));
                r_dp <= sat66(66'(r_wx) + 66'(r_wy) + 66'(r_pz));
                if (r_sen) begin
                    r_qx <= sat66(66'(r_wx) - 66'(fmul(r_sdx, r_pz)));
                    r_qy <= sat66(66'(r_wy) - 66'(fmul(r_sdy, r_pz)));
                end else begin
                    r_qx <= r_wx;
                    r_qy <= r_wy;
                end
            end
            ST_SHAD: begin
                r_gx <= projk(33'(r_qx) - 33'(r_qy), FRAC_BITS);
                r_gy <= projk(33'(r_qx) + 33'(r_qy), FRAC_BITS + 1);
            end
            default: ;
        endcase
    end

    assign o_valid       = r_ov;
    assign o_left_edge   = r_ol;
    assign o_top_edge    = r_ot;
    assign o_right_edge  = r_or;
    assign o_bottom_edge = r_ob;
    assign o_near_depth  = r_on;
    assign o_far_depth   = r_of;

`ifndef ASSERT_OFF
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_q_valid) else $error("stall with empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_left_edge))
        else $error("result dropped while stalled");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid) else $error("pop from empty queue");
`endif
endmodule
